[rtl/core/video_dram_bus_interface_macros.svh]
// Assertion macros for the video DRAM bus interface.
`ifndef VIDEO_DRAM_BUS_INTERFACE_MACROS_SVH
`define VIDEO_DRAM_BUS_INTERFACE_MACROS_SVH

`ifndef SYNTH
`define VDBI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define VDBI_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VDBI_ASSERT(lbl, clk, rstn, prop, msg)
`define VDBI_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/vdbi_pkg.sv]
// Types and constants shared by the video DRAM bus interface modules.
package vdbi_pkg;

    localparam int unsigned STORE_DEPTH = 32'h004F_FFE0;
    localparam int unsigned STORE_AW    = 23;
    localparam int unsigned REG_COUNT   = 32;
    localparam int unsigned REG_AW      = 5;
    localparam int unsigned REG_W       = 16;

    localparam logic [24:0] STORE_END   = 25'h04F_FFE0;
    localparam logic [23:0] MEM_TOP     = 24'h4F_FFDF;
    localparam logic [23:0] REG_BASE    = 24'h4F_FFE0;
    localparam logic [23:0] REG_TOP     = 24'h4F_FFFF;
    localparam logic [23:0] STATUS_ADDR = 24'h4F_FFE1;

    localparam logic [REG_AW-1:0] STATUS_INDEX = 5'd1;
    localparam logic [REG_W-1:0]  STATUS_MASK  = 16'h00FE;
    localparam logic [REG_W-1:0]  BYTE_MASK    = 16'h00FF;
    localparam logic [2:0]        COUNT_MAX    = 3'd7;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;

    typedef struct packed {
        logic                en;
        logic                we;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          wdata;
    } store_req_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [REG_AW-1:0] addr;
        logic [REG_W-1:0]  wdata;
    } reg_req_t;

endpackage

[rtl/core/video_dram_bus_interface.sv]
// Top level of the video DRAM bus interface: sequencer plus store and register RAMs.
//
//  channel | valid    | stall     | payload
//  --------+----------+-----------+-------------------------------------------------
//  in      | in_valid | in_stall  | cmd, access_size, address, write_data, trigger
//  out     | out_valid| out_stall | read_data, in_range
//
// Store accesses are decoded in IDLE, issue one byte per cycle on the single store RAM
// port in MEM, drain the last read and post the result from DONE. Register reads pass
// through REG_RD on the way to DONE; register writes and misses go straight to DONE.
// Reset clears the register file through per-entry valid bits; no clearing pass.
// A finished result waits in the output register while the next beat is taken;
// a new result waits in the sequencer only if that register is still stalled.
module video_dram_bus_interface #(
    parameter int unsigned BOOT_READS = 4,
    parameter int unsigned ROM_OFFSET = 4194304
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [1:0]  access_size,
    input  logic [23:0] address,
    input  logic [31:0] write_data,
    input  logic        trigger,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        in_range
);

    import vdbi_pkg::*;

    `include "video_dram_bus_interface_macros.svh"

    store_req_t       st_req;
    reg_req_t         rg_req;
    logic [7:0]       st_rdata;
    logic [REG_W-1:0] rg_rdata;

    vdbi_seq #(
        .BOOT_READS (BOOT_READS),
        .ROM_OFFSET (ROM_OFFSET)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .access_size (access_size),
        .address     (address),
        .write_data  (write_data),
        .trigger     (trigger),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .in_range    (in_range),
        .st_req      (st_req),
        .st_rdata    (st_rdata),
        .rg_req      (rg_req),
        .rg_rdata    (rg_rdata)
    );

    vdbi_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (st_req.en),
        .we    (st_req.we),
        .addr  (st_req.addr),
        .wdata (st_req.wdata),
        .rdata (st_rdata)
    );

    vdbi_ram #(
        .WIDTH (REG_W),
        .DEPTH (REG_COUNT)
    ) u_regs (
        .clk   (clk),
        .en    (rg_req.en),
        .we    (rg_req.we),
        .addr  (rg_req.addr),
        .wdata (rg_req.wdata),
        .rdata (rg_rdata)
    );

    `VDBI_ASSERT(a_store_in_bounds, clk, rst_n, st_req.en |-> (st_req.addr < STORE_DEPTH), "store access past end")
    `VDBI_ASSERT(a_one_target, clk, rst_n, !(st_req.en && rg_req.en), "store and register RAM hit together")
    `VDBI_ASSERT(a_busy_after_beat, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "beat taken without going busy")
    `VDBI_ASSERT_RST(a_reset_quiet, clk, !rst_n |-> (!out_valid && !in_stall), "handshake active in reset")

endmodule

[rtl/core/vdbi_ram.sv]
// Generic single-port synchronous RAM with registered read.
module vdbi_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end

endmodule

[rtl/core/vdbi_seq.sv]
// Access sequencer: decodes a bus beat and steps it through the store and register RAMs.
module vdbi_seq #(
    parameter int unsigned BOOT_READS = 4,
    parameter int unsigned ROM_OFFSET = 4194304
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    cmd,
    input  logic [1:0]              access_size,
    input  logic [23:0]             address,
    input  logic [31:0]             write_data,
    input  logic                    trigger,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [31:0]             read_data,
    output logic                    in_range,
    output vdbi_pkg::store_req_t    st_req,
    input  logic [7:0]              st_rdata,
    output vdbi_pkg::reg_req_t      rg_req,
    input  logic [vdbi_pkg::REG_W-1:0] rg_rdata
);

    import vdbi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEM,
        S_REG_RD,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [24:0]          addr_reg, addr_next;
    logic [2:0]           left_reg, left_next;
    logic                 wr_reg, wr_next;
    logic [31:0]          wbuf_reg, wbuf_next;
    logic [31:0]          data_reg, data_next;
    logic                 hit_reg, hit_next;
    logic                 pend_reg, pend_next;
    logic                 pend_ok_reg, pend_ok_next;
    logic                 stclr_reg, stclr_next;
    logic                 byte_rd_reg, byte_rd_next;
    logic                 rg_ok_reg, rg_ok_next;
    logic [REG_COUNT-1:0] vld_reg, vld_next;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          read_data_reg, read_data_next;
    logic                 in_range_reg, in_range_next;

    logic                 accept;
    logic [2:0]           nbytes;
    logic                 boot;
    logic [24:0]          rom_base;
    logic                 mem_hit;
    logic                 reg_hit;
    logic [REG_AW-1:0]    ridx;
    logic [3:0]           csum;
    logic                 lane_ok;
    logic [REG_W-1:0]     rval;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    assign nbytes   = (access_size == SIZE_BYTE) ? 3'd1 :
                      (access_size == SIZE_WORD) ? 3'd2 : 3'd4;
    assign boot     = (cmd == CMD_READ) && (access_size != SIZE_BYTE)
                      && (cnt_reg < 3'(BOOT_READS));
    assign rom_base = {1'b0, address} + 25'(ROM_OFFSET);
    assign mem_hit  = (address <= MEM_TOP);
    assign reg_hit  = !mem_hit && (address <= REG_TOP);
    assign ridx     = REG_AW'(address - REG_BASE);
    assign csum     = {1'b0, cnt_reg} + ((access_size == SIZE_WORD) ? 4'd1 : 4'd2);
    assign lane_ok  = (addr_reg < STORE_END);
    assign rval     = rg_ok_reg ? rg_rdata : '0;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        left_next      = left_reg;
        wr_next        = wr_reg;
        wbuf_next      = wbuf_reg;
        data_next      = data_reg;
        hit_next       = hit_reg;
        pend_next      = 1'b0;
        pend_ok_next   = pend_ok_reg;
        stclr_next     = stclr_reg;
        byte_rd_next   = byte_rd_reg;
        rg_ok_next     = rg_ok_reg;
        vld_next       = vld_reg;
        out_valid_next = out_valid_reg && out_stall;
        read_data_next = read_data_reg;
        in_range_next  = in_range_reg;
        st_req         = '0;
        rg_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    data_next = '0;
                    left_next = nbytes;
                    unique case (access_size)
                        SIZE_BYTE: wbuf_next = {write_data[7:0], 24'h0};
                        SIZE_WORD: wbuf_next = {write_data[15:0], 16'h0};
                        default:   wbuf_next = write_data;
                    endcase
                    if (boot)
                    begin
                        addr_next  = rom_base;
                        wr_next    = CMD_READ;
                        hit_next   = (rom_base < STORE_END);
                        cnt_next   = (csum > {1'b0, COUNT_MAX}) ? COUNT_MAX : csum[2:0];
                        state_next = S_MEM;
                    end
                    else if (mem_hit)
                    begin
                        addr_next  = {1'b0, address};
                        wr_next    = cmd;
                        hit_next   = 1'b1;
                        state_next = S_MEM;
                    end
                    else if (reg_hit)
                    begin
                        hit_next    = 1'b1;
                        rg_req.en   = 1'b1;
                        rg_req.addr = ridx;
                        if (cmd == CMD_WRITE)
                        begin
                            rg_req.we      = 1'b1;
                            rg_req.wdata   = (access_size == SIZE_BYTE)
                                             ? (write_data[REG_W-1:0] & BYTE_MASK)
                                             : write_data[REG_W-1:0];
                            vld_next[ridx] = 1'b1;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            rg_ok_next   = vld_reg[ridx];
                            byte_rd_next = (access_size == SIZE_BYTE);
                            // triggered byte read of the status register clears its ready bit
                            stclr_next   = (access_size == SIZE_BYTE) && trigger
                                           && (address == STATUS_ADDR);
                            state_next   = S_REG_RD;
                        end
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        state_next = S_DONE;
                    end
                end
            end

            S_MEM:
            begin
                // issue one byte a cycle; read data lands in the cycle after its issue
                if (left_reg != 3'd0)
                begin
                    st_req.en    = lane_ok;
                    st_req.we    = wr_reg;
                    st_req.addr  = addr_reg[STORE_AW-1:0];
                    st_req.wdata = wbuf_reg[31:24];
                    wbuf_next    = {wbuf_reg[23:0], 8'h0};
                    addr_next    = addr_reg + 25'd1;
                    left_next    = left_reg - 3'd1;
                    pend_next    = (wr_reg == CMD_READ);
                    pend_ok_next = lane_ok;
                end
                else
                begin
                    state_next = S_DONE;
                end
                if (pend_reg)
                    data_next = {data_reg[23:0], pend_ok_reg ? st_rdata : 8'h00};
            end

            S_REG_RD:
            begin
                data_next = byte_rd_reg ? {24'h0, rval[7:0]} : {16'h0, rval};
                if (stclr_reg)
                begin
                    rg_req.en              = 1'b1;
                    rg_req.we              = 1'b1;
                    rg_req.addr            = STATUS_INDEX;
                    rg_req.wdata           = rval & STATUS_MASK;
                    vld_next[STATUS_INDEX] = 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    read_data_next = data_reg;
                    in_range_next  = hit_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            left_reg      <= '0;
            wr_reg        <= CMD_READ;
            wbuf_reg      <= '0;
            data_reg      <= '0;
            hit_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            pend_ok_reg   <= 1'b0;
            stclr_reg     <= 1'b0;
            byte_rd_reg   <= 1'b0;
            rg_ok_reg     <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            read_data_reg <= '0;
            in_range_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            addr_reg      <= addr_next;
            left_reg      <= left_next;
            wr_reg        <= wr_next;
            wbuf_reg      <= wbuf_next;
            data_reg      <= data_next;
            hit_reg       <= hit_next;
            pend_reg      <= pend_next;
            pend_ok_reg   <= pend_ok_next;
            stclr_reg     <= stclr_next;
            byte_rd_reg   <= byte_rd_next;
            rg_ok_reg     <= rg_ok_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
            read_data_reg <= read_data_next;
            in_range_reg  <= in_range_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign in_range  = in_range_reg;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the video DRAM bus interface: directed script, then random beats.
module tb_top;
    import vdbi_pkg::*;

    localparam int unsigned BOOT_READS    = 4;
    localparam int unsigned ROM_OFFSET    = 4194304;
    localparam logic [1:0]  SIZE_LONG_ALT = 2'd3;
    localparam int          HALF_PERIOD   = 4;
    localparam int          RESET_CYCLES  = 11;
    localparam int          RANDOM_BEATS  = 1425;
    localparam int          HOLD_AT       = 300;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_AT      = 700;
    localparam int          TAIL_CYCLES   = 20;
    localparam int          LIMIT_NS      = 4000000;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  size;
        logic [23:0] addr;
        logic [31:0] wdata;
        logic        trig;
    } bus_beat_t;

    typedef struct packed {
        logic [31:0] data;
        logic        hit;
    } bus_reply_t;

    typedef struct packed {
        bus_beat_t  beat;
        logic       typed;
        bus_reply_t want;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [1:0]  access_size;
    logic [23:0] address;
    logic [31:0] write_data;
    logic        trigger;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] read_data;
    logic        in_range;

    // predictor state
    logic [7:0]       dram_bytes [int unsigned];
    logic [REG_W-1:0] ctrl_regs [REG_COUNT];
    logic [2:0]       boot_reads_seen;

    bus_reply_t  pending_replies [$];
    int unsigned written_bases [$];
    script_row_t script_rows [$];
    bit          hold_off_req;
    int          errors;

    video_dram_bus_interface #(
        .BOOT_READS (BOOT_READS),
        .ROM_OFFSET (ROM_OFFSET)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .access_size (access_size),
        .address     (address),
        .write_data  (write_data),
        .trigger     (trigger),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .in_range    (in_range)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic int unsigned beat_bytes(logic [1:0] size);
        return (size == SIZE_BYTE) ? 1 : (size == SIZE_WORD) ? 2 : 4;
    endfunction

    // big-endian gather; lanes past the store's end read zero
    function automatic logic [31:0] dram_read(int unsigned a, int unsigned n);
        logic [31:0] v;
        v = '0;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (a + i < STORE_DEPTH && dram_bytes.exists(a + i))
                v = {v[23:0], dram_bytes[a + i]};
            else
                v = {v[23:0], 8'h00};
        end
        return v;
    endfunction

    function automatic bit bytes_known(int unsigned a, int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (a + i < STORE_DEPTH && !dram_bytes.exists(a + i))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bus_reply_t predict_reply(bus_beat_t b);
        int unsigned      nbytes;
        int unsigned      base;
        int unsigned      step;
        logic [REG_AW-1:0] idx;
        logic [REG_W-1:0] r;
        logic [31:0]      lane;
        bus_reply_t       rep;
        nbytes = beat_bytes(b.size);
        idx = REG_AW'(b.addr - REG_BASE);
        rep = '0;
        if (b.cmd == CMD_READ)
        begin
            if (b.size != SIZE_BYTE && boot_reads_seen < BOOT_READS)
            begin
                // boot overlay: remapped to the ROM image
                base = b.addr + ROM_OFFSET;
                step = boot_reads_seen + ((b.size == SIZE_WORD) ? 1 : 2);
                boot_reads_seen = (step > COUNT_MAX) ? COUNT_MAX : step[2:0];
                rep.data = dram_read(base, nbytes);
                rep.hit = (base < STORE_DEPTH);
            end
            else if (b.addr <= MEM_TOP)
            begin
                rep.data = dram_read(b.addr, nbytes);
                rep.hit = 1'b1;
            end
            else if (b.addr <= REG_TOP)
            begin
                r = ctrl_regs[idx];
                rep.data = {16'h0000, (b.size == SIZE_BYTE) ? (r & BYTE_MASK) : r};
                rep.hit = 1'b1;
                if (b.size == SIZE_BYTE && b.trig && b.addr == STATUS_ADDR)
                    ctrl_regs[STATUS_INDEX] = ctrl_regs[STATUS_INDEX] & STATUS_MASK;
            end
        end
        else
        begin
            if (b.addr <= MEM_TOP)
            begin
                for (int unsigned i = 0; i < nbytes; i++)
                begin
                    lane = b.wdata >> (8 * (nbytes - 1 - i));
                    if (b.addr + i < STORE_DEPTH)
                        dram_bytes[b.addr + i] = lane[7:0];
                end
                rep.hit = 1'b1;
            end
            else if (b.addr <= REG_TOP)
            begin
                ctrl_regs[idx] = (b.size == SIZE_BYTE) ? (b.wdata[15:0] & BYTE_MASK)
                                                       : b.wdata[15:0];
                rep.hit = 1'b1;
            end
        end
        return rep;
    endfunction

    // mostly write-then-read-back traffic, plus register pokes and misses
    function automatic bus_beat_t random_beat();
        bus_beat_t   b;
        int unsigned pick;
        pick = $urandom_range(99);
        b.cmd = CMD_WRITE;
        b.size = 2'($urandom_range(3));
        b.wdata = $urandom();
        b.trig = 1'($urandom_range(1));
        b.addr = '0;
        if (pick < 35)
        begin
            case ($urandom_range(2))
                0: b.addr = 24'($urandom_range(255));
                1: b.addr = MEM_TOP - 24'($urandom_range(31));
                default: b.addr = 24'($urandom_range(MEM_TOP));
            endcase
            written_bases.push_back(32'(b.addr));
        end
        else if (pick < 70 && written_bases.size() > 0)
        begin
            b.cmd = CMD_READ;
            b.addr = 24'(written_bases[$urandom_range(written_bases.size() - 1)]);
            // shrink until every lane inside the store has been written
            if (!bytes_known(b.addr, beat_bytes(b.size)))
                b.size = SIZE_WORD;
            if (!bytes_known(b.addr, 2))
                b.size = SIZE_BYTE;
        end
        else if (pick < 90)
        begin
            b.cmd = 1'($urandom_range(1));
            b.addr = ($urandom_range(3) == 0) ? STATUS_ADDR
                                              : REG_BASE + 24'($urandom_range(31));
        end
        else
        begin
            b.cmd = 1'($urandom_range(1));
            b.addr = 24'($urandom_range(24'hFF_FFFF, 24'h50_0000));
        end
        return b;
    endfunction

    function automatic script_row_t dir_row(logic c, logic [1:0] s, logic [23:0] a,
                                            logic [31:0] wd, logic t, logic typed,
                                            logic [31:0] data, logic hit);
        script_row_t row;
        row.beat = '{c, s, a, wd, t};
        row.typed = typed;
        row.want = '{data, hit};
        return row;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
        errors++;
    endtask

    task automatic send_beat(bus_beat_t b, logic typed, bus_reply_t want);
        @(negedge clk);
        in_valid = 1'b1;
        cmd = b.cmd;
        access_size = b.size;
        address = b.addr;
        write_data = b.wdata;
        trigger = b.trig;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (typed)
        begin
            void'(predict_reply(b));
            pending_replies.push_back(want);
        end
        else
            pending_replies.push_back(predict_reply(b));
    endtask

    // result checker
    always @(posedge clk)
    begin
        bus_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("unexpected beat", read_data, 32'h0);
            else
            begin
                want = pending_replies.pop_front();
                if (read_data !== want.data)
                    report_mismatch("read_data", read_data, want.data);
                if (in_range !== want.hit)
                    report_mismatch("in_range", {31'h0, in_range}, {31'h0, want.hit});
            end
        end
    end

    // receiver: stall pattern changes mode when its random mode length runs out
    initial
    begin
        int mode;
        int mode_left;
        out_stall = 1'b0;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(3);
                mode_left = $urandom_range(80, 16);
            end
            mode_left--;
            case (mode)
                0: out_stall = 1'b0;
                1: out_stall = ($urandom_range(3) == 0);
                2: out_stall = ($urandom_range(3) != 0);
                default: out_stall = mode_left[2];
            endcase
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        bus_beat_t b;
        int        burst_left;
        int        gap;
        rst_n = 1'b1;
        in_valid = 1'b0;
        cmd = CMD_READ;
        access_size = SIZE_BYTE;
        address = '0;
        write_data = '0;
        trigger = 1'b0;
        hold_off_req = 1'b0;
        errors = 0;
        boot_reads_seen = '0;
        foreach (ctrl_regs[i])
            ctrl_regs[i] = '0;

        // seed the ROM image and the store's top before the boot reads
        script_rows.push_back(dir_row(CMD_WRITE, SIZE_LONG, 24'h40_0000, 32'h1122_3344,
                                      0, 1, 32'h0, 1));
        script_rows.push_back(dir_row(CMD_WRITE, SIZE_LONG, 24'h4F_FFDC, 32'hA1B2_C3D4,
                                      0, 1, 32'h0, 1));
        // long across the store's end: upper lanes dropped
        script_rows.push_back(dir_row(CMD_WRITE, SIZE_LONG, 24'h4F_FFDE, 32'hDEAD_BEEF,
                                      0, 1, 32'h0, 1));
        script_rows.push_back(dir_row(CMD_READ, SIZE_BYTE, REG_BASE, 32'h0, 0, 1, 32'h0, 1));
        // boot overlay: word, long across the end, byte untouched, word at a register
        script_rows.push_back(dir_row(CMD_READ, SIZE_WORD, 24'h00_0000, 32'h0, 0, 0, 0, 0));
        script_rows.push_back(dir_row(CMD_READ, SIZE_LONG, 24'h0F_FFDE, 32'h0, 0, 0, 0, 0));
        script_rows.push_back(dir_row(CMD_READ, SIZE_BYTE, 24'h40_0001, 32'h0, 0, 0, 0, 0));
        script_rows.push_back(dir_row(CMD_READ, SIZE_WORD, 24'h4F_FFE2, 32'h0, 0, 0, 0, 0));
        script_rows.push_back(dir_row(CMD_READ, SIZE_WORD, 24'h40_0002, 32'h0, 0, 0, 0, 0));
        script_rows.push_back(dir_row(CMD_WRITE, SIZE_WORD, MEM_TOP, 32'h0000_CAFE,
                                      0, 1, 32'h0, 1));
        script_rows.push_back(dir_row(CMD_READ, SIZE_WORD, MEM_TOP, 32'h0, 0, 0, 0, 0));
        // status register: plain read, long read with trigger, clearing read
        script_rows.push_back(dir_row(CMD_WRITE, SIZE_WORD, STATUS_ADDR, 32'hFFFF_ABCD,
                                      0, 1, 32'h0, 1));
        script_rows.push_back(dir_row(CMD_READ, SIZE_BYTE, STATUS_ADDR, 32'h0,
                                      0, 1, 32'h0000_00CD, 1));
        script_rows.push_back(dir_row(CMD_READ, SIZE_LONG, STATUS_ADDR, 32'h0,
                                      1, 1, 32'h0000_ABCD, 1));
        script_rows.push_back(dir_row(CMD_READ, SIZE_BYTE, STATUS_ADDR, 32'h0,
                                      1, 1, 32'h0000_00CD, 1));
        script_rows.push_back(dir_row(CMD_READ, SIZE_WORD, STATUS_ADDR, 32'h0,
                                      0, 1, 32'h0000_00CC, 1));
        script_rows.push_back(dir_row(CMD_WRITE, SIZE_BYTE, REG_TOP, 32'hFFFF_FF5A,
                                      0, 1, 32'h0, 1));
        script_rows.push_back(dir_row(CMD_READ, SIZE_LONG_ALT, REG_TOP, 32'h0,
                                      0, 1, 32'h0000_005A, 1));
        script_rows.push_back(dir_row(CMD_WRITE, SIZE_LONG, 24'h50_0000, 32'hFFFF_FFFF,
                                      0, 1, 32'h0, 0));
        script_rows.push_back(dir_row(CMD_READ, SIZE_LONG, 24'hFF_FFFF, 32'h0,
                                      1, 1, 32'h0, 0));
        script_rows.push_back(dir_row(CMD_WRITE, SIZE_LONG_ALT, 24'h00_0000, 32'h0102_0304,
                                      0, 1, 32'h0, 1));
        script_rows.push_back(dir_row(CMD_READ, SIZE_LONG_ALT, 24'h00_0000, 32'h0,
                                      0, 0, 0, 0));
        script_rows.push_back(dir_row(CMD_READ, SIZE_BYTE, 24'h00_0003, 32'h0, 0, 0, 0, 0));
        script_rows.push_back(dir_row(CMD_WRITE, SIZE_BYTE, 24'h00_0000, 32'hFFFF_FFFF,
                                      1, 1, 32'h0, 1));
        script_rows.push_back(dir_row(CMD_READ, SIZE_LONG, 24'h00_0000, 32'h0, 0, 0, 0, 0));

        // clean falling edge after time zero so the async reset is always seen
        #(HALF_PERIOD / 2);
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script_rows[i])
            send_beat(script_rows[i].beat, script_rows[i].typed, script_rows[i].want);

        burst_left = 0;
        for (int k = 0; k < RANDOM_BEATS; k++)
        begin
            if (k == HOLD_AT)
                hold_off_req = 1'b1;
            if (k == DRAIN_AT)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                while (pending_replies.size() != 0)
                    @(posedge clk);
            end
            // keep offering beats while the receiver holds off
            if (burst_left <= 0 && !hold_off_req)
            begin
                burst_left = $urandom_range(24, 1);
                if ($urandom_range(3) != 0)
                begin
                    gap = $urandom_range(10, 1);
                    @(negedge clk);
                    in_valid = 1'b0;
                    cmd = 1'($urandom_range(1));
                    access_size = 2'($urandom_range(3));
                    address = 24'($urandom());
                    write_data = $urandom();
                    trigger = 1'($urandom_range(1));
                    repeat (gap - 1) @(negedge clk);
                end
            end
            if (burst_left > 0)
                burst_left--;
            b = random_beat();
            send_beat(b, 1'b0, '0);
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
